// File: src/spg_pkg.sv
// servo pulse generator package: shared types, codes and constants
// no dependencies; used by every module of the servo pulse generator
`timescale 1ns / 1ps

package spg_pkg;

  // field widths
  localparam int unsigned US_W     = 15;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // timing and limits
  localparam int unsigned PERIOD_TICKS      = 40000;
  localparam int unsigned MAX_ANGLE_DEF     = 180;
  localparam int unsigned MAX_PULSE_US      = 20000;
  localparam int unsigned DEG_SPAN          = 180;
  localparam int unsigned RESET_WIDTH_TICKS = 3000;
  localparam int unsigned MIN_PULSE_RESET   = 1000;
  localparam int unsigned MAX_PULSE_RESET   = 2000;

  // register indexes (paddr bit 2)
  localparam logic REG_MIN_PULSE = 1'b0;
  localparam logic REG_MAX_PULSE = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_US   = 2'd1,
    MODE_DEG  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef struct packed {
    logic [US_W-1:0] min_us;
    logic [US_W-1:0] max_us;
  } spg_cfg_t;

  // request leaving the degree mapping pipeline
  typedef struct packed {
    mode_t           mode;
    logic [US_W-1:0] value;
    logic            deg_bad;
    logic [US_W-1:0] deg_us;
  } spg_item_t;

endpackage

// File: src/spg_cfg_regs.sv
// servo pulse generator configuration registers behind an apb-style port
// depends on spg_pkg
`timescale 1ns / 1ps

module spg_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spg_pkg::ADDR_W-1:0] paddr,
  input  logic [spg_pkg::DATA_W-1:0] pwdata,
  output logic [spg_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output spg_pkg::spg_cfg_t          cfg
);

  logic                     wr_en;
  logic                     reg_idx;
  logic [spg_pkg::US_W-1:0] wr_val;
  logic                     val_ok;
  logic [spg_pkg::US_W-1:0] min_us_r;
  logic [spg_pkg::US_W-1:0] max_us_r;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[spg_pkg::ADDR_W-1];
  assign wr_val  = pwdata[spg_pkg::US_W-1:0];
  // out of range writes leave the register alone
  assign val_ok  = (wr_val <= spg_pkg::US_W'(spg_pkg::MAX_PULSE_US));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_us_r <= spg_pkg::US_W'(spg_pkg::MIN_PULSE_RESET);
      max_us_r <= spg_pkg::US_W'(spg_pkg::MAX_PULSE_RESET);
    end else if (wr_en && val_ok) begin
      if (reg_idx == spg_pkg::REG_MIN_PULSE) begin
        min_us_r <= wr_val;
      end else begin
        max_us_r <= wr_val;
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      spg_pkg::REG_MIN_PULSE: begin
        prdata = {{(spg_pkg::DATA_W - spg_pkg::US_W){1'b0}}, min_us_r};
      end
      default: begin
        prdata = {{(spg_pkg::DATA_W - spg_pkg::US_W){1'b0}}, max_us_r};
      end
    endcase
  end

  assign cfg.min_us = min_us_r;
  assign cfg.max_us = max_us_r;

endmodule

// File: src/spg_deg_map.sv
// servo pulse generator input register and degree-to-microsecond pipeline
// depends on spg_pkg; divides by 180 with a reciprocal multiply and one correction
`timescale 1ns / 1ps

module spg_deg_map #(
  parameter int unsigned MAX_ANGLE = spg_pkg::MAX_ANGLE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [spg_pkg::US_W-1:0] in_value,
  input  spg_pkg::spg_cfg_t        cfg,
  output logic                     item_valid,
  input  logic                     item_ready,
  output spg_pkg::spg_item_t       item
);

  localparam int unsigned US_W  = spg_pkg::US_W;
  localparam int unsigned DEG_W = $clog2(MAX_ANGLE + 1);
  localparam int unsigned PW    = US_W + DEG_W;
  localparam int unsigned K     = PW + 8;
  localparam int unsigned MW    = K - 7;
  localparam int unsigned QW    = PW - 7;
  localparam int unsigned UW    = ((QW > US_W) ? QW : US_W) + 1;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << K) / spg_pkg::DEG_SPAN);

  // stage 1: input register
  logic                v1_r;
  spg_pkg::mode_t      mode1_r;
  logic [US_W-1:0]     value1_r;
  // stage 2: span times angle
  logic                v2_r;
  spg_pkg::mode_t      mode2_r;
  logic [US_W-1:0]     value2_r;
  logic                bad2_r;
  logic [PW-1:0]       prod2_r;
  // stage 3: quotient estimate
  logic                v3_r;
  spg_pkg::mode_t      mode3_r;
  logic [US_W-1:0]     value3_r;
  logic                bad3_r;
  logic [PW-1:0]       prod3_r;
  logic [QW-1:0]       q0_r;

  logic                rdy1;
  logic                rdy2;
  logic                rdy3;
  logic                bad1_nxt;
  logic [US_W-1:0]     span;
  logic [PW-1:0]       prod2_nxt;
  logic [PW+MW-1:0]    recip_prod;
  logic [PW-1:0]       q0x180;
  logic [PW-1:0]       rem;
  logic                corr;
  logic [QW-1:0]       quot;
  logic [UW-1:0]       us_sum;

  assign rdy3     = !v3_r || item_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // angle range and span sanity
  assign bad1_nxt  = (value1_r > US_W'(MAX_ANGLE)) || (cfg.max_us < cfg.min_us);
  assign span      = cfg.max_us - cfg.min_us;
  assign prod2_nxt = PW'(span) * PW'(value1_r[DEG_W-1:0]);

  assign recip_prod = (PW + MW)'(prod2_r) * (PW + MW)'(RECIP);

  // estimate is exact or one short
  assign q0x180 = PW'(q0_r * spg_pkg::DEG_SPAN);
  assign rem    = prod3_r - q0x180;
  assign corr   = (rem >= PW'(spg_pkg::DEG_SPAN));
  assign quot   = q0_r + QW'(corr);
  assign us_sum = UW'(quot) + UW'(cfg.min_us);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      mode1_r  <= spg_pkg::mode_t'(in_mode);
      value1_r <= in_value;
    end
    if (rdy2 && v1_r) begin
      mode2_r  <= mode1_r;
      value2_r <= value1_r;
      bad2_r   <= bad1_nxt;
      prod2_r  <= prod2_nxt;
    end
    if (rdy3 && v2_r) begin
      mode3_r  <= mode2_r;
      value3_r <= value2_r;
      bad3_r   <= bad2_r;
      prod3_r  <= prod2_r;
      q0_r     <= recip_prod[K +: QW];
    end
  end

  assign item_valid   = v3_r;
  assign item.mode    = mode3_r;
  assign item.value   = value3_r;
  assign item.deg_bad = bad3_r || (|us_sum[UW-1:US_W]);
  assign item.deg_us  = us_sum[US_W-1:0];

  a_quot_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && mode3_r == spg_pkg::MODE_DEG && !bad3_r) |->
      (prod3_r >= q0x180) && (rem < PW'(2 * spg_pkg::DEG_SPAN)))
    else $error("reciprocal quotient estimate off by more than one");

  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !item_ready) |=> (v3_r && $stable(prod3_r) && $stable(q0_r)))
    else $error("stage 3 request lost while downstream stalled");

endmodule

// File: src/spg_core.sv
// servo pulse generator period counter, width latches and result register
// depends on spg_pkg; takes requests from spg_deg_map
`timescale 1ns / 1ps

module spg_core (
  input  logic                clk,
  input  logic                rst_n,
  input  spg_pkg::spg_cfg_t   cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  spg_pkg::spg_item_t  item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_servo_out,
  output logic                out_status
);

  localparam int unsigned CNT_W = spg_pkg::CNT_W;

  logic [CNT_W-1:0]         period_count_r;
  logic [CNT_W-1:0]         period_count_nxt;
  logic                     level_r;
  logic                     level_nxt;
  logic [CNT_W-1:0]         pending_r;
  logic [CNT_W-1:0]         pending_nxt;
  logic [CNT_W-1:0]         active_r;
  logic [CNT_W-1:0]         active_nxt;
  logic                     status_nxt;
  logic                     out_valid_r;
  logic                     out_servo_out_r;
  logic                     out_status_r;
  logic                     take;
  logic [CNT_W-1:0]         cnt_inc;
  logic [spg_pkg::US_W-1:0] cand_us;
  logic                     cand_bad;

  assign item_ready = !out_valid_r || !out_stall;
  assign take       = item_valid && item_ready;

  // counter saturates instead of wrapping
  assign cnt_inc  = (period_count_r == '1) ? period_count_r : period_count_r + CNT_W'(1);
  assign cand_us  = (item.mode == spg_pkg::MODE_DEG) ? item.deg_us : item.value;
  assign cand_bad = ((item.mode == spg_pkg::MODE_DEG) && item.deg_bad) ||
                    (cand_us < cfg.min_us) || (cand_us > cfg.max_us);

  always_comb begin
    period_count_nxt = period_count_r;
    level_nxt        = level_r;
    pending_nxt      = pending_r;
    active_nxt       = active_r;
    status_nxt       = 1'b0;
    unique case (item.mode) inside
      spg_pkg::MODE_TICK: begin
        period_count_nxt = cnt_inc;
        if (level_r) begin
          if (cnt_inc >= active_r) level_nxt = 1'b0;
        end else if (cnt_inc >= CNT_W'(spg_pkg::PERIOD_TICKS)) begin
          active_nxt       = pending_r;
          level_nxt        = 1'b1;
          period_count_nxt = '0;
        end
      end
      spg_pkg::MODE_US, spg_pkg::MODE_DEG: begin
        status_nxt = cand_bad;
        if (!cand_bad) pending_nxt = {cand_us, 1'b0};
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r <= '0;
      level_r        <= 1'b0;
      pending_r      <= CNT_W'(spg_pkg::RESET_WIDTH_TICKS);
      active_r       <= CNT_W'(spg_pkg::RESET_WIDTH_TICKS);
      out_valid_r    <= 1'b0;
    end else if (take) begin
      period_count_r <= period_count_nxt;
      level_r        <= level_nxt;
      pending_r      <= pending_nxt;
      active_r       <= active_nxt;
      out_valid_r    <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_servo_out_r <= level_nxt;
      out_status_r    <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_servo_out = out_servo_out_r;
  assign out_status    = out_status_r;

  a_rise_latch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(level_r) |-> (period_count_r == '0) && (active_r == $past(pending_r)))
    else $error("period start did not clear counter or latch pending width");

  a_pending_cmd_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != $past(pending_r)) |->
      $past(take && (item.mode == spg_pkg::MODE_US || item.mode == spg_pkg::MODE_DEG)))
    else $error("pending width changed without a position command");

endmodule

// File: src/servo_pulse_generator_unit.sv
// servo pulse generator top level: apb registers, degree mapping pipeline, core
// depends on spg_pkg, spg_cfg_regs, spg_deg_map, spg_core
`timescale 1ns / 1ps

// drives one rc servo line with a 20 ms frame counted in half-microsecond ticks.
// every request (tick, position in us, position in degrees) yields exactly one
// result carrying the line level after the request and a reject status. the
// block takes one request per clock while in_stall is low and presents its
// result after acceptance through an input register, a span-times-angle
// multiply stage, a reciprocal multiply stage for the divide by 180, then the
// state and result register. requests move through in order, so a later tick
// sees every earlier position command. a new position lands in the pending
// width and goes live at the next period start. min and max pulse widths sit
// at byte addresses 0 and 4; writes whose low 15 bits exceed 20000 us are dropped.
// registers are expected to change only while no request is in flight.

module servo_pulse_generator_unit #(
  parameter int unsigned MAX_ANGLE = spg_pkg::MAX_ANGLE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic [spg_pkg::US_W-1:0]   in_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_servo_out,
  output logic                       out_status,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spg_pkg::ADDR_W-1:0] paddr,
  input  logic [spg_pkg::DATA_W-1:0] pwdata,
  output logic [spg_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  spg_pkg::spg_cfg_t  cfg;
  spg_pkg::spg_item_t item;
  logic               item_valid;
  logic               item_ready;

  // min/max pulse registers
  spg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register plus degree mapping, three stages
  spg_deg_map #(
    .MAX_ANGLE (MAX_ANGLE)
  ) u_deg_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // period counter, width latches, result register
  spg_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_servo_out (out_servo_out),
    .out_status    (out_status)
  );

endmodule

// File: test/tb.sv
// self-checking testbench for servo_pulse_generator_unit: request/result traffic,
// register writes over the apb port and the period counter, against an inline model
// depends on spg_pkg and the servo_pulse_generator_unit rtl
`timescale 1ns / 1ps

module tb;

  // run guard: far above the slowest legal run (every request waiting out both
  // the longest sender gap and the longest receiver stall)
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // cycles to let the four-stage pipe empty before touching registers
  localparam int unsigned PIPE_SETTLE = 8;
  // long receiver hold-off used to fill the pipe
  localparam int unsigned HOLD_CYCLES = 300;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_mode;
  logic [spg_pkg::US_W-1:0]    in_value;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_servo_out;
  logic                        out_status;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [spg_pkg::ADDR_W-1:0]  paddr;
  logic [spg_pkg::DATA_W-1:0]  pwdata;
  logic [spg_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  // one predicted result per accepted request, oldest first
  typedef struct {
    spg_pkg::mode_t mode;
    logic           servo;
    logic           status;
  } servo_result_t;

  servo_result_t servo_result_q[$];

  // model state of the servo line and its registers
  int unsigned pulse_min;
  int unsigned pulse_max;
  int unsigned period_cnt;
  int unsigned pending_w;
  int unsigned active_w;
  bit          line_high;

  int unsigned err_count;
  int unsigned cycle_count;
  // 0 turns idling off, otherwise roughly one burst every idle_odds requests/cycles
  int unsigned idle_odds;
  bit          hold_req;

  servo_pulse_generator_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_servo_out (out_servo_out),
    .out_status    (out_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // servo model
  // -------------------------------------------------------------------------

  // range check and store of a position; returns the reject flag
  function automatic logic take_width(input int unsigned us);
    if (us < pulse_min || us > pulse_max) return 1'b1;
    pending_w = (us * 2) & 32'hFFFF;
    return 1'b0;
  endfunction

  // apply one request to the model and return the line level and reject flag
  function automatic void advance_servo(input spg_pkg::mode_t m,
                                        input logic [spg_pkg::US_W-1:0] v,
                                        output logic lvl, output logic rej);
    longint unsigned span;
    longint unsigned us;
    rej = 1'b0;
    case (m)
      spg_pkg::MODE_TICK: begin
        // counter saturates rather than wrapping
        if (period_cnt < 32'hFFFF) period_cnt++;
        if (line_high) begin
          if (period_cnt >= active_w) line_high = 1'b0;
        end else if (period_cnt >= spg_pkg::PERIOD_TICKS) begin
          // period start: latch the pending width and raise the line
          active_w   = pending_w;
          line_high  = 1'b1;
          period_cnt = 0;
        end
      end
      spg_pkg::MODE_US: rej = take_width(v);
      spg_pkg::MODE_DEG: begin
        if (v > spg_pkg::MAX_ANGLE_DEF || pulse_max < pulse_min) begin
          rej = 1'b1;
        end else begin
          span = pulse_max - pulse_min;
          us   = span * v / spg_pkg::DEG_SPAN + pulse_min;
          if (us > 32'h7FFF) rej = 1'b1;
          else rej = take_width(int'(us));
        end
      end
      default: rej = 1'b1;
    endcase
    lvl = line_high;
  endfunction

  // -------------------------------------------------------------------------
  // request side
  // -------------------------------------------------------------------------

  // offer one request, hold it until accepted, then queue its predicted result
  task automatic send_request(input spg_pkg::mode_t m, input logic [spg_pkg::US_W-1:0] v);
    servo_result_t r;
    int unsigned   gap;
    if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      gap = $urandom_range(11, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    r.mode = m;
    advance_servo(m, v, r.servo, r.status);
    servo_result_q.push_back(r);
  endtask

  // stop offering and wait for every outstanding result, then let the pipe settle
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (servo_result_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [spg_pkg::US_W-1:0] clamp_us(input int x);
    if (x < 0) return '0;
    if (x > 32767) return '1;
    return x[spg_pkg::US_W-1:0];
  endfunction

  // random request, mostly near the interesting edges of the current limits
  task automatic random_request(output spg_pkg::mode_t m,
                                output logic [spg_pkg::US_W-1:0] v);
    int unsigned r;
    r = $urandom_range(99, 0);
    v = spg_pkg::US_W'($urandom_range(32767, 0));
    if (r < 50) begin
      m = spg_pkg::MODE_TICK;
    end else if (r < 72) begin
      m = spg_pkg::MODE_US;
      case ($urandom_range(3, 0))
        0: v = clamp_us(int'(pulse_min) + int'($urandom_range(4, 0)) - 2);
        1: v = clamp_us(int'(pulse_max) + int'($urandom_range(4, 0)) - 2);
        2: if (pulse_min <= pulse_max) begin
          v = spg_pkg::US_W'($urandom_range(pulse_max, pulse_min));
        end
        default: ;
      endcase
    end else if (r < 94) begin
      m = spg_pkg::MODE_DEG;
      if ($urandom_range(3, 0) != 0) v = spg_pkg::US_W'($urandom_range(182, 0));
    end else begin
      m = spg_pkg::MODE_RSVD;
    end
  endtask

  // -------------------------------------------------------------------------
  // register port
  // -------------------------------------------------------------------------

  task automatic apb_xfer(input logic wr, input logic [spg_pkg::ADDR_W-1:0] addr,
                          input logic [spg_pkg::DATA_W-1:0] wdata,
                          output logic [spg_pkg::DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a pulse limit, mirror it in the model, read it back
  task automatic write_pulse_reg(input logic idx, input logic [spg_pkg::DATA_W-1:0] data);
    logic [spg_pkg::DATA_W-1:0] rd;
    int unsigned                v;
    int unsigned                want;
    apb_xfer(1'b1, {idx, 2'b00}, data, rd);
    // only 15 bits are kept; values above the pulse ceiling are dropped
    v = data & 32'h7FFF;
    if (v <= spg_pkg::MAX_PULSE_US) begin
      if (idx == spg_pkg::REG_MIN_PULSE) pulse_min = v;
      else pulse_max = v;
    end
    apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
    want = (idx == spg_pkg::REG_MIN_PULSE) ? pulse_min : pulse_max;
    if (rd !== want) begin
      $display("%0t: register %0d readback expected %0d actual %0d", $time, idx, want, rd);
      err_count++;
    end
  endtask

  task automatic set_pulse_limits(input int unsigned mn, input int unsigned mx);
    drain_requests();
    write_pulse_reg(spg_pkg::REG_MIN_PULSE, mn);
    write_pulse_reg(spg_pkg::REG_MAX_PULSE, mx);
  endtask

  // -------------------------------------------------------------------------
  // result side
  // -------------------------------------------------------------------------

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(11, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    servo_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (servo_result_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, servo %0b status %0b",
                 $time, out_servo_out, out_status);
        err_count++;
      end else begin
        r = servo_result_q.pop_front();
        if (out_servo_out !== r.servo) begin
          $display("%0t: %s servo_out expected %0b actual %0b",
                   $time, r.mode.name(), r.servo, out_servo_out);
          err_count++;
        end
        if (out_status !== r.status) begin
          $display("%0t: %s status expected %0b actual %0b",
                   $time, r.mode.name(), r.status, out_status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // field extremes, every mode and the out-of-range and reserved-mode reject paths at the reset limits
  task automatic test_directed_requests();
    send_request(spg_pkg::MODE_TICK, '0);
    send_request(spg_pkg::MODE_TICK, '1);
    send_request(spg_pkg::MODE_US, 15'd1000);
    send_request(spg_pkg::MODE_US, 15'd2000);
    send_request(spg_pkg::MODE_US, 15'd999);
    send_request(spg_pkg::MODE_US, 15'd2001);
    send_request(spg_pkg::MODE_US, '0);
    send_request(spg_pkg::MODE_US, '1);
    send_request(spg_pkg::MODE_DEG, '0);
    send_request(spg_pkg::MODE_DEG, 15'd180);
    send_request(spg_pkg::MODE_DEG, 15'd181);
    send_request(spg_pkg::MODE_DEG, 15'd90);
    send_request(spg_pkg::MODE_DEG, 15'd1);
    send_request(spg_pkg::MODE_DEG, '1);
    // unused mode: no state change, status reports a reject
    send_request(spg_pkg::MODE_RSVD, '0);
    send_request(spg_pkg::MODE_RSVD, '1);
    send_request(spg_pkg::MODE_US, 15'd1500);
  endtask

  // inverted limits, widest limits, dropped and masked writes
  task automatic test_register_settings();
    // max below min: every degree and microsecond command is rejected
    set_pulse_limits(2000, 1000);
    send_request(spg_pkg::MODE_DEG, '0);
    send_request(spg_pkg::MODE_US, 15'd1500);
    set_pulse_limits(0, spg_pkg::MAX_PULSE_US);
    send_request(spg_pkg::MODE_DEG, 15'd180);
    send_request(spg_pkg::MODE_DEG, 15'd1);
    send_request(spg_pkg::MODE_US, '0);
    send_request(spg_pkg::MODE_US, 15'd20000);
    send_request(spg_pkg::MODE_US, 15'd20001);
    drain_requests();
    // above the ceiling: ignored
    write_pulse_reg(spg_pkg::REG_MIN_PULSE, 32'd20001);
    write_pulse_reg(spg_pkg::REG_MAX_PULSE, 32'd32767);
    // upper pwdata bits are not part of the register
    write_pulse_reg(spg_pkg::REG_MIN_PULSE, 32'hFFFF_81F4);
    send_request(spg_pkg::MODE_US, 15'd499);
    send_request(spg_pkg::MODE_US, 15'd500);
    set_pulse_limits(spg_pkg::MIN_PULSE_RESET, spg_pkg::MAX_PULSE_RESET);
  endtask

  // ticks with an occasional random command mixed in
  task automatic tick_run(input int unsigned n_ticks, input int unsigned cmd_odds);
    spg_pkg::mode_t           m;
    logic [spg_pkg::US_W-1:0] v;
    repeat (n_ticks) begin
      if (cmd_odds != 0 && $urandom_range(cmd_odds - 1, 0) == 0) begin
        random_request(m, v);
        send_request(m, v);
      end
      send_request(spg_pkg::MODE_TICK, spg_pkg::US_W'($urandom_range(32767, 0)));
    end
  endtask

  // ticks advancing the period counter while the pending width moves around,
  // including the widest and the zero width; the line stays low mid-period
  task automatic test_tick_counting();
    idle_odds = 32;
    tick_run(200, 16);
    set_pulse_limits(0, spg_pkg::MAX_PULSE_US);
    send_request(spg_pkg::MODE_US, 15'd20000);
    tick_run(40, 0);
    send_request(spg_pkg::MODE_US, '0);
    tick_run(40, 0);
    set_pulse_limits(spg_pkg::MIN_PULSE_RESET, spg_pkg::MAX_PULSE_RESET);
  endtask

  // receiver holds off long enough for the pipe to back up into in_stall;
  // the sender keeps offering, then pauses until everything has drained
  task automatic test_backpressure();
    spg_pkg::mode_t           m;
    logic [spg_pkg::US_W-1:0] v;
    idle_odds = 0;
    hold_req = 1'b1;
    repeat (40) begin
      random_request(m, v);
      send_request(m, v);
    end
    drain_requests();
    idle_odds = 8;
    repeat (40) begin
      random_request(m, v);
      send_request(m, v);
    end
    drain_requests();
  endtask

  // random traffic in chunks, each under a fresh register setting
  task automatic test_random_traffic();
    spg_pkg::mode_t           m;
    logic [spg_pkg::US_W-1:0] v;
    int unsigned              a;
    int unsigned              b;
    for (int chunk = 0; chunk < 4; chunk++) begin
      a = $urandom_range(spg_pkg::MAX_PULSE_US, 0);
      b = $urandom_range(spg_pkg::MAX_PULSE_US, 0);
      case ($urandom_range(4, 0))
        0: set_pulse_limits(spg_pkg::MIN_PULSE_RESET, spg_pkg::MAX_PULSE_RESET);
        1: set_pulse_limits(0, spg_pkg::MAX_PULSE_US);
        2: set_pulse_limits(a, b);
        3: set_pulse_limits(a, a);
        default: set_pulse_limits((a > b) ? a : b, (a > b) ? b : a);
      endcase
      if ($urandom_range(1, 0) == 0)
        write_pulse_reg(1'($urandom_range(1, 0)),
                        $urandom_range(32767, spg_pkg::MAX_PULSE_US + 1));
      // last chunk runs with no idling on either side
      idle_odds = (chunk == 3) ? 0 : 6;
      repeat (300) begin
        random_request(m, v);
        send_request(m, v);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = spg_pkg::MODE_TICK;
    in_value  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    err_count = 0;
    cycle_count = 0;
    idle_odds = 8;
    hold_req  = 1'b0;
    // model reset state
    pulse_min  = spg_pkg::MIN_PULSE_RESET;
    pulse_max  = spg_pkg::MAX_PULSE_RESET;
    period_cnt = 0;
    pending_w  = spg_pkg::RESET_WIDTH_TICKS;
    active_w   = spg_pkg::RESET_WIDTH_TICKS;
    line_high  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_requests();
    test_register_settings();
    test_tick_counting();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    while (servo_result_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/spg_pkg.sv
src/spg_cfg_regs.sv
src/spg_deg_map.sv
src/spg_core.sv
src/servo_pulse_generator_unit.sv
test/tb.sv
